FILE: rtl/sobel_edge_magnitude_stream_defines.svh
// Assertion macros for the Sobel edge magnitude stream.
`ifndef SOBEL_EDGE_MAGNITUDE_STREAM_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_STREAM_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SEM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sobel edge magnitude: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sobel edge magnitude: next-cycle check failed");
`else
`define SEM_ASSERT_SAME(label, clk, rst, ante, cons)
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/sem_pkg.sv
// Types and constants shared by the Sobel edge magnitude stream.
`timescale 1ns / 1ps

package sem_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);     // column counter
   localparam int ROW_W      = $clog2(MAX_HEIGHT);    // row counter
   localparam int WIDTH_W    = 12;                    // image_width register
   localparam int HEIGHT_W   = 13;                    // image_height register
   localparam int CSR_DATA_W = 13;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       start_of_frame;
   } req_type;

   typedef struct packed {
      logic [7:0]       magnitude;
      logic [COL_W-1:0] centre_col;
      logic [ROW_W-1:0] centre_row;
      logic             frame_last;
   } rsp_type;

   // One line store entry: upper row above middle row.
   typedef struct packed {
      logic [7:0] upper;
      logic [7:0] middle;
   } line_entry_type;

   // 3x3 neighbourhood without the centre tap: left, centre and right columns, top/mid/bottom rows.
   typedef struct packed {
      logic [7:0] tl;
      logic [7:0] ml;
      logic [7:0] bl;
      logic [7:0] tc;
      logic [7:0] bc;
      logic [7:0] tr;
      logic [7:0] mr;
      logic [7:0] br;
   } taps_type;

endpackage

FILE: rtl/sem_line_buf.sv
// Two-row line store: one write and one registered read per cycle.
`timescale 1ns / 1ps

module sem_line_buf (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [sem_pkg::COL_W-1:0]      wr_addr,
   input  sem_pkg::line_entry_type        wr_data,
   input  logic                           rd_en,
   input  logic [sem_pkg::COL_W-1:0]      rd_addr,
   output sem_pkg::line_entry_type        rd_data
);
   import sem_pkg::*;

   line_entry_type mem [MAX_WIDTH];
   line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sem_kernel.sv
// Sobel 3x3 gradients and saturated L1 magnitude.
`timescale 1ns / 1ps

module sem_kernel (
   input  sem_pkg::taps_type taps,
   output logic [7:0]        magnitude
);
   import sem_pkg::*;

   logic [9:0]         sum_left, sum_right, sum_top, sum_bottom;
   logic signed [10:0] gx, gy;
   logic [9:0]         abs_gx, abs_gy;
   logic [10:0]        l1;

   always_comb begin
      sum_left   = {2'b00, taps.tl} + {1'b0, taps.ml, 1'b0} + {2'b00, taps.bl};
      sum_right  = {2'b00, taps.tr} + {1'b0, taps.mr, 1'b0} + {2'b00, taps.br};
      sum_top    = {2'b00, taps.tl} + {1'b0, taps.tc, 1'b0} + {2'b00, taps.tr};
      sum_bottom = {2'b00, taps.bl} + {1'b0, taps.bc, 1'b0} + {2'b00, taps.br};
      gx = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
      gy = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
      // |g| <= 1020, so ten bits hold it
      abs_gx = gx[10] ? 10'(-gx) : gx[9:0];
      abs_gy = gy[10] ? 10'(-gy) : gy[9:0];
      l1 = {1'b0, abs_gx} + {1'b0, abs_gy};
      magnitude = (l1 > 11'd255) ? 8'hFF : l1[7:0];
   end

endmodule

FILE: rtl/sobel_edge_magnitude_stream.sv
// Top level of the streaming 3x3 Sobel edge magnitude unit.
`timescale 1ns / 1ps
// Usage
//   req_*  : grayscale pixels in raster order, one transfer per pixel.
//            start_of_frame puts that pixel at column 0, row 0.
//   rsp_*  : one transfer per interior pixel, for centre (x-1, y-1) when the
//            pixel at (x, y) with x >= 2, y >= 2 arrives. Border pixels give
//            no transfer; the consumer writes them as zero. frame_last marks
//            centre (width-2, height-2).
//   csr_*  : index 0 image_width, index 1 image_height; write only while idle.
//            Width below 3 gives no results; 0 acts as 1, large values clamp.
// Timing
//   Two stages: input/line-store read, then kernel into the output register.
//   rsp_valid rises once the pixel has passed the stage 1 and result registers.
//   Throughput is one pixel per cycle when not stalled, set by one line store
//   read and one write each cycle; a write to the address being read is forwarded.
// Reset
//   Clears counters and stage valids, loads 640 x 480 into the size registers.
//   Line stores and window are not cleared.
// Stall
//   A stalled receiver holds the result register; the second stage then holds
//   only when it carries a result, and req_ready drops while it holds.

`include "sobel_edge_magnitude_stream_defines.svh"

module sobel_edge_magnitude_stream (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sem_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sem_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  sem_pkg::csr_index_type              csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sem_pkg::*;

   // size registers
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [WIDTH_W-1:0]  eff_width;     // 1..2048
   logic [HEIGHT_W-1:0] eff_height;    // 1..4096

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // stage 0 (input side)
   logic             req_xfer;
   logic [COL_W-1:0] cur_x;
   logic [ROW_W-1:0] cur_y;
   logic             cur_emit, cur_last, cur_fwd;
   logic [WIDTH_W-1:0]  cur_x_ext;
   logic [HEIGHT_W-1:0] cur_y_ext;

   // stage 1 (line store data out, kernel)
   logic             s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0] s1_x_ff;
   logic [ROW_W-1:0] s1_y_ff;
   logic [7:0]       s1_pix_ff;
   logic             s1_emit_ff, s1_last_ff;
   logic             s1_fwd_ff;
   line_entry_type   s1_fwd_data_ff;
   line_entry_type   s1_rd_data;
   logic [7:0]       s1_top, s1_mid;
   logic             s1_adv;

   // last two columns of the window
   logic [7:0] win_tl_ff, win_ml_ff, win_bl_ff;
   logic [7:0] win_tc_ff, win_mc_ff, win_bc_ff;

   taps_type   taps;
   logic [7:0] kernel_mag;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    rsp_free;

   // ------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0)
         eff_width = WIDTH_W'(1);
      else if (width_ff > WIDTH_W'(MAX_WIDTH))
         eff_width = WIDTH_W'(MAX_WIDTH);
      else
         eff_width = width_ff;
      if (height_ff == '0)
         eff_height = HEIGHT_W'(1);
      else if (height_ff > HEIGHT_W'(MAX_HEIGHT))
         eff_height = HEIGHT_W'(MAX_HEIGHT);
      else
         eff_height = height_ff;
   end

   // ------------------------------------------------------------------
   // Handshake: result register frees the second stage, which frees input
   // ------------------------------------------------------------------
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || rsp_free);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_xfer  = req_valid && req_ready;

   // ------------------------------------------------------------------
   // Stage 0: position, result decision, line store read
   // ------------------------------------------------------------------
   always_comb begin
      cur_x = req_data.start_of_frame ? '0 : col_ff;
      cur_y = req_data.start_of_frame ? '0 : row_ff;
      cur_x_ext = {1'b0, cur_x};
      cur_y_ext = {1'b0, cur_y};
      cur_emit = (cur_x >= COL_W'(2)) && (cur_y >= ROW_W'(2)) &&
                 (cur_x_ext < eff_width) && (cur_y_ext < eff_height);
      cur_last = (cur_x_ext == eff_width - WIDTH_W'(1)) &&
                 (cur_y_ext == eff_height - HEIGHT_W'(1));
      // stage 1 writes its column this cycle; a read of the same column
      // would see the old entry, so take the new one directly
      cur_fwd = s1_adv && (s1_x_ff == cur_x);

      // counters wrap at the limit, also when already past it
      col_in = col_ff;
      row_in = row_ff;
      if (req_xfer) begin
         if (cur_x_ext + WIDTH_W'(1) >= eff_width) begin
            col_in = '0;
            row_in = (cur_y_ext + HEIGHT_W'(1) >= eff_height) ? '0 : cur_y + ROW_W'(1);
         end else begin
            col_in = cur_x + COL_W'(1);
            row_in = cur_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   sem_line_buf u_line_buf (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_x_ff),
      .wr_data ({s1_mid, s1_pix_ff}),
      .rd_en   (req_xfer),
      .rd_addr (cur_x),
      .rd_data (s1_rd_data)
   );

   // ------------------------------------------------------------------
   // Stage 1 registers
   // ------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer)
         s1_valid_in = 1'b1;
      else if (s1_adv)
         s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_x_ff        <= cur_x;
         s1_y_ff        <= cur_y;
         s1_pix_ff      <= req_data.pixel;
         s1_emit_ff     <= cur_emit;
         s1_last_ff     <= cur_last;
         s1_fwd_ff      <= cur_fwd;
         s1_fwd_data_ff <= '{upper: s1_mid, middle: s1_pix_ff};
      end
   end

   assign s1_top = s1_fwd_ff ? s1_fwd_data_ff.upper  : s1_rd_data.upper;
   assign s1_mid = s1_fwd_ff ? s1_fwd_data_ff.middle : s1_rd_data.middle;

   // window shifts once per pixel leaving stage 1
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_tl_ff <= win_tc_ff;
         win_ml_ff <= win_mc_ff;
         win_bl_ff <= win_bc_ff;
         win_tc_ff <= s1_top;
         win_mc_ff <= s1_mid;
         win_bc_ff <= s1_pix_ff;
      end
   end

   assign taps = '{tl: win_tl_ff, ml: win_ml_ff, bl: win_bl_ff,
                   tc: win_tc_ff, bc: win_bc_ff,
                   tr: s1_top,    mr: s1_mid,    br: s1_pix_ff};

   sem_kernel u_kernel (
      .taps      (taps),
      .magnitude (kernel_mag)
   );

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_emit_ff)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         rsp_data_ff.magnitude  <= kernel_mag;
         rsp_data_ff.centre_col <= s1_x_ff - COL_W'(1);
         rsp_data_ff.centre_row <= s1_y_ff - ROW_W'(1);
         rsp_data_ff.frame_last <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   // an accepted pixel always lands in stage 1
   `SEM_ASSERT_NEXT(a_req_to_s1, clock, reset, req_xfer, s1_valid_ff)
   // a held stage 1 keeps its pixel and position
   `SEM_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_adv,
                    s1_valid_ff && $stable(s1_pix_ff) && $stable(s1_x_ff))
   // only interior positions are ever reported
   `SEM_ASSERT_SAME(a_s1_interior, clock, reset, s1_valid_ff && s1_emit_ff,
                    s1_x_ff >= COL_W'(2) && s1_y_ff >= ROW_W'(2))
   // no input accepted while stage 1 is blocked behind a full result register
   `SEM_ASSERT_SAME(a_no_overrun, clock, reset,
                    s1_valid_ff && s1_emit_ff && rsp_valid_ff && !rsp_ready,
                    !req_ready)

endmodule
